// ----- rtl/jdr_pkg.sv -----
package jdr_pkg;

	// Default widths
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int ACC_WIDTH_DEF    = 24;

	// Fixed field widths
	localparam int STICK_W  = 16;
	localparam int DZ_W     = 15;
	localparam int LIMIT_W  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DIR_W    = 3;
	// Compare width: widest sample plus sign
	localparam int CMP_W    = STICK_W + 1;

	// Register reset values
	localparam logic [DZ_W-1:0]    DEAD_ZONE_RST = 15'd30;
	localparam logic [LIMIT_W-1:0] LIMIT_X_RST   = 16'd1200;
	localparam logic [LIMIT_W-1:0] LIMIT_Y_RST   = 16'd2000;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_X   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Y   = 2'd2;

	typedef enum logic [DIR_W-1:0] {
		DIR_NONE  = 3'd0,
		DIR_UP    = 3'd1,
		DIR_DOWN  = 3'd2,
		DIR_LEFT  = 3'd3,
		DIR_RIGHT = 3'd4
	} dir_t;

	// Threshold flags of one axis
	typedef struct packed {
		logic pos;
		logic neg;
	} fire_t;

endpackage

// ----- rtl/jdr_axis.sv -----
module jdr_axis #(
	parameter int SAMPLE_WIDTH = jdr_pkg::SAMPLE_WIDTH_DEF,
	parameter int ACC_WIDTH    = jdr_pkg::ACC_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          clr,
	input  logic [SAMPLE_WIDTH-1:0]       sample,
	input  logic [jdr_pkg::DZ_W-1:0]      dead_zone,
	input  logic [jdr_pkg::LIMIT_W-1:0]   limit,
	output jdr_pkg::fire_t                fire
);

	localparam int CW = jdr_pkg::CMP_W;

	logic [SAMPLE_WIDTH-1:0] prev_q;
	logic signed [ACC_WIDTH-1:0] acc_q;

	logic signed [CW-1:0] s_c, p_c, dz_c, ndz_c;
	logic s_hi, s_lo, p_hi, p_lo;
	logic signed [ACC_WIDTH-1:0] lim_a, base, acc_new;
	logic signed [ACC_WIDTH:0] sum;
	logic signed [ACC_WIDTH-1:0] sat_max, sat_min;

	// Dead zone compares
	assign s_c   = $signed({{(CW-SAMPLE_WIDTH){sample[SAMPLE_WIDTH-1]}}, sample});
	assign p_c   = $signed({{(CW-SAMPLE_WIDTH){prev_q[SAMPLE_WIDTH-1]}}, prev_q});
	assign dz_c  = $signed({{(CW-jdr_pkg::DZ_W){1'b0}}, dead_zone});
	assign ndz_c = -dz_c;
	assign s_hi  = s_c > dz_c;
	assign s_lo  = s_c < ndz_c;
	assign p_hi  = p_c > dz_c;
	assign p_lo  = p_c < ndz_c;

	// Preset on first tilt
	assign lim_a = $signed({{(ACC_WIDTH-jdr_pkg::LIMIT_W){1'b0}}, limit});
	always_comb begin
		base = acc_q;
		if (s_hi && !p_hi)
			base = lim_a;
		if (s_lo && !p_lo)
			base = -lim_a;
	end

	// Saturating add, cleared inside the dead zone
	assign sum = {base[ACC_WIDTH-1], base}
		+ $signed({{(ACC_WIDTH+1-SAMPLE_WIDTH){sample[SAMPLE_WIDTH-1]}}, sample});
	assign sat_max = $signed({1'b0, {(ACC_WIDTH-1){1'b1}}});
	assign sat_min = $signed({1'b1, {(ACC_WIDTH-1){1'b0}}});
	always_comb begin
		if (!(s_hi || s_lo))
			acc_new = '0;
		else if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1])
			acc_new = sum[ACC_WIDTH] ? sat_min : sat_max;
		else
			acc_new = sum[ACC_WIDTH-1:0];
	end

	assign fire.pos = acc_new > lim_a;
	assign fire.neg = acc_new < -lim_a;

	// Axis state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			acc_q  <= '0;
		end else if (en) begin
			prev_q <= sample;
			acc_q  <= clr ? '0 : acc_new;
		end
	end

endmodule

// ----- rtl/jdr_decide.sv -----
module jdr_decide (
	input  jdr_pkg::fire_t fire_x,
	input  jdr_pkg::fire_t fire_y,
	output jdr_pkg::dir_t  dir,
	output logic           clr_x,
	output logic           clr_y
);

	// Order: right, left, down, up
	always_comb begin
		dir   = jdr_pkg::DIR_NONE;
		clr_x = 1'b0;
		clr_y = 1'b0;
		priority if (fire_x.pos) begin
			dir   = jdr_pkg::DIR_RIGHT;
			clr_x = 1'b1;
		end else if (fire_x.neg) begin
			dir   = jdr_pkg::DIR_LEFT;
			clr_x = 1'b1;
		end else if (fire_y.pos) begin
			dir   = jdr_pkg::DIR_DOWN;
			clr_y = 1'b1;
		end else if (fire_y.neg) begin
			dir   = jdr_pkg::DIR_UP;
			clr_y = 1'b1;
		end else begin
			dir   = jdr_pkg::DIR_NONE;
		end
	end

endmodule

// ----- rtl/joystick_direction_repeat.sv -----
// Channel  Dir  Word                         Handshake
// s_axis   in   tdata[15:0] stick_x,          s_tvalid / s_tready
//               tdata[31:16] stick_y
// m_axis   out  tdata[2:0] direction          m_tvalid / m_tready
// cfg      in   cfg_index, cfg_data           cfg_we (no wait)
//
// Each word passes an input register, then axis update and priority
// select into the output register; one word per cycle while m_tready
// does not stall. Axis state is updated when a word moves into the output
// register. Reset clears state and valids and loads register defaults.
// A stall on m_tready holds the output word and the input register.
module joystick_direction_repeat #(
	parameter int SAMPLE_WIDTH = jdr_pkg::SAMPLE_WIDTH_DEF,
	parameter int ACC_WIDTH    = jdr_pkg::ACC_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [31:0]                      s_tdata,   // stick_x, stick_y
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,   // direction, zero pad
	input  logic                             cfg_we,
	input  logic [jdr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [jdr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [jdr_pkg::DZ_W-1:0]    dead_zone_q;
	logic [jdr_pkg::LIMIT_W-1:0] limit_x_q, limit_y_q;

	logic                    valid_s1;
	logic [SAMPLE_WIDTH-1:0] stick_x_s1, stick_y_s1;
	logic                    out_valid_q;
	jdr_pkg::dir_t           dir_q, dir_w;

	logic           advance;
	jdr_pkg::fire_t fire_x, fire_y;
	logic           clr_x, clr_y;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= jdr_pkg::DEAD_ZONE_RST;
			limit_x_q   <= jdr_pkg::LIMIT_X_RST;
			limit_y_q   <= jdr_pkg::LIMIT_Y_RST;
		end else if (cfg_we) begin
			if (cfg_index == jdr_pkg::REG_DEAD_ZONE)
				dead_zone_q <= cfg_data[jdr_pkg::DZ_W-1:0];
			if (cfg_index == jdr_pkg::REG_LIMIT_X)
				limit_x_q <= cfg_data[jdr_pkg::LIMIT_W-1:0];
			if (cfg_index == jdr_pkg::REG_LIMIT_Y)
				limit_y_q <= cfg_data[jdr_pkg::LIMIT_W-1:0];
		end
	end

	// Flow control
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			stick_x_s1 <= s_tdata[SAMPLE_WIDTH-1:0];
			stick_y_s1 <= s_tdata[jdr_pkg::STICK_W +: SAMPLE_WIDTH];
		end
	end

	jdr_axis #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .ACC_WIDTH(ACC_WIDTH)) u_axis_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.clr       (clr_x),
		.sample    (stick_x_s1),
		.dead_zone (dead_zone_q),
		.limit     (limit_x_q),
		.fire      (fire_x)
	);

	jdr_axis #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .ACC_WIDTH(ACC_WIDTH)) u_axis_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.clr       (clr_y),
		.sample    (stick_y_s1),
		.dead_zone (dead_zone_q),
		.limit     (limit_y_q),
		.fire      (fire_y)
	);

	jdr_decide u_decide (
		.fire_x (fire_x),
		.fire_y (fire_y),
		.dir    (dir_w),
		.clr_x  (clr_x),
		.clr_y  (clr_y)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			dir_q <= dir_w;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(8-jdr_pkg::DIR_W){1'b0}}, dir_q};

endmodule
